>>> rtl/core/knn_pkg.sv
package knn_pkg;

    localparam int COORD_W     = 16;
    localparam int ID_W        = 16;
    localparam int DIST_W      = 36;
    localparam int CFG_W       = 5;
    localparam int SQ_W        = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0] NBR_RESET = CFG_W'(8);

    localparam logic CMD_CENTRE = 1'b0;
    localparam logic CMD_POINT  = 1'b1;

    // one item on its way from the front to the list
    typedef struct packed {
        logic                      cmd;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [ID_W-1:0]           id;
        logic                      last;
        logic [DIST_W-1:0]         dist_sq;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

endpackage

>>> rtl/core/knn_front.sv
module knn_front
    import knn_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_command,
    input  logic signed [COORD_W-1:0] i_x_coord,
    input  logic signed [COORD_W-1:0] i_y_coord,
    input  logic signed [COORD_W-1:0] i_z_coord,
    input  logic [ID_W-1:0]           i_point_id,
    input  logic                      i_last_candidate,
    input  logic [QLVL_W-1:0]         i_q_level,
    output logic                      o_push,
    output t_item                     o_push_item
);

    logic signed [COORD_W-1:0] r_cx, r_cy, r_cz;
    logic                      r_a_v, r_b_v;
    t_item                     r_a_item, r_b_item;
    logic signed [COORD_W:0]   r_dx, r_dy, r_dz;
    logic [SQ_W-1:0]           r_sx, r_sy, r_sz;
    logic signed [2*COORD_W+1:0] px, py, pz;
    logic [QLVL_W+1:0]         credit;
    logic                      accept;
    t_item                     in_item;

    // hold off while the queue cannot take every beat already in flight
    assign credit  = (QLVL_W+2)'(i_q_level) + (QLVL_W+2)'(r_a_v) + (QLVL_W+2)'(r_b_v);
    assign o_stall = credit >= (QLVL_W+2)'(QUEUE_DEPTH);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        in_item      = '0;
        in_item.cmd  = i_command;
        in_item.x    = i_x_coord;
        in_item.y    = i_y_coord;
        in_item.z    = i_z_coord;
        in_item.id   = i_point_id;
        in_item.last = i_last_candidate;
    end

    assign px = r_dx * r_dx;
    assign py = r_dy * r_dy;
    assign pz = r_dz * r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_cx  <= '0;
            r_cy  <= '0;
            r_cz  <= '0;
        end else begin
            r_a_v <= accept;
            r_b_v <= r_a_v;
            if (accept && i_command == CMD_CENTRE) begin
                r_cx <= i_x_coord;
                r_cy <= i_y_coord;
                r_cz <= i_z_coord;
            end
        end
        r_a_item <= in_item;
        r_dx     <= (COORD_W+1)'(i_x_coord) - (COORD_W+1)'(r_cx);
        r_dy     <= (COORD_W+1)'(i_y_coord) - (COORD_W+1)'(r_cy);
        r_dz     <= (COORD_W+1)'(i_z_coord) - (COORD_W+1)'(r_cz);
        r_b_item <= r_a_item;
        r_sx     <= px[SQ_W-1:0];
        r_sy     <= py[SQ_W-1:0];
        r_sz     <= pz[SQ_W-1:0];
    end

    always_comb begin
        o_push_item         = r_b_item;
        o_push_item.dist_sq = DIST_W'(r_sx) + DIST_W'(r_sy) + DIST_W'(r_sz);
    end
    assign o_push = r_b_v;

endmodule

>>> rtl/core/knn_queue.sv
module knn_queue
    import knn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_item             i_push_item,
    input  logic              i_pop,
    output t_q_head           o_head,
    output logic [QLVL_W-1:0] o_level
);

    t_item               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QLVL_W-1:0]   r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 1'b1;
            end else if (!i_push && i_pop) begin
                r_level <= r_level - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    assign o_head.valid = r_level != '0;
    assign o_head.item  = r_mem[r_rd_ptr];
    assign o_level      = r_level;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_level < QLVL_W'(QUEUE_DEPTH) || i_pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_level != '0)
        else $error("queue read while empty");

endmodule

>>> rtl/core/knn_back.sv
module knn_back
    import knn_pkg::*;
#(
    parameter int MAX_NEIGHBOURS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  t_q_head                   i_head,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [COORD_W-1:0] o_out_x,
    output logic signed [COORD_W-1:0] o_out_y,
    output logic signed [COORD_W-1:0] o_out_z,
    output logic [ID_W-1:0]           o_out_id,
    output logic [DIST_W-1:0]         o_out_distance,
    output logic                      o_is_empty,
    output logic                      o_last_result
);

    localparam int NE = MAX_NEIGHBOURS + 1;
    localparam int CW = $clog2(MAX_NEIGHBOURS + 2);

    typedef enum logic {ST_RUN, ST_EMIT} t_state;

    t_state                    r_state;
    logic [CFG_W-1:0]          r_nbr;
    logic [CW-1:0]             r_count;
    logic [DIST_W-1:0]         r_dist [NE];
    logic signed [COORD_W-1:0] r_x [NE];
    logic signed [COORD_W-1:0] r_y [NE];
    logic signed [COORD_W-1:0] r_z [NE];
    logic [ID_W-1:0]           r_id [NE];

    logic                      r_ov;
    logic signed [COORD_W-1:0] r_ox, r_oy, r_oz;
    logic [ID_W-1:0]           r_oid;
    logic [DIST_W-1:0]         r_odist;
    logic                      r_oempty, r_olast;

    logic [CW-1:0]     k_eff, cap, held;
    logic [NE-1:0]     lt, lt_prev;
    logic [DIST_W-1:0] tail_dist, d;
    logic              discard, out_free;
    t_item             it;

    always_comb begin
        if (r_nbr == '0) begin
            k_eff = CW'(1);
        end else if (32'(r_nbr) > MAX_NEIGHBOURS) begin
            k_eff = CW'(MAX_NEIGHBOURS);
        end else begin
            k_eff = CW'(r_nbr);
        end
        cap  = k_eff + 1'b1;
        // cut the list when k was lowered since the last query
        held = (r_count > cap) ? cap : r_count;
    end

    assign it = i_head.item;
    assign d  = it.dist_sq;

    // list is sorted, so lt is a prefix; ties keep the earlier arrival ahead
    always_comb begin
        tail_dist = '0;
        for (int i = 0; i < NE; i++) begin
            lt[i] = (CW'(i) < held) && (r_dist[i] <= d);
            if (CW'(i) == cap - 1'b1) begin
                tail_dist = r_dist[i];
            end
        end
        discard = (held == cap) && (d >= tail_dist);
    end
    assign lt_prev = {lt[NE-2:0], 1'b1};

    assign o_pop    = (r_state == ST_RUN) && i_head.valid;
    assign out_free = !r_ov || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_nbr   <= NBR_RESET;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_nbr <= i_cfg_data;
            end
            if (r_state == ST_EMIT && out_free) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_RUN: begin
                    if (i_head.valid) begin
                        if (it.cmd == CMD_CENTRE) begin
                            r_count <= '0;
                        end else begin
                            if (!discard) begin
                                if (!lt[0]) begin
                                    r_dist[0] <= d;
                                    r_x[0]    <= it.x;
                                    r_y[0]    <= it.y;
                                    r_z[0]    <= it.z;
                                    r_id[0]   <= it.id;
                                end
                                for (int i = 1; i < NE; i++) begin
                                    if (!lt[i]) begin
                                        if (lt_prev[i]) begin
                                            r_dist[i] <= d;
                                            r_x[i]    <= it.x;
                                            r_y[i]    <= it.y;
                                            r_z[i]    <= it.z;
                                            r_id[i]   <= it.id;
                                        end else begin
                                            r_dist[i] <= r_dist[i-1];
                                            r_x[i]    <= r_x[i-1];
                                            r_y[i]    <= r_y[i-1];
                                            r_z[i]    <= r_z[i-1];
                                            r_id[i]   <= r_id[i-1];
                                        end
                                    end
                                end
                                r_count <= (held == cap) ? cap : held + 1'b1;
                            end else begin
                                r_count <= held;
                            end
                            if (it.last) begin
                                r_state <= ST_EMIT;
                            end
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        if (r_count <= CW'(1)) begin
                            r_ox     <= '0;
                            r_oy     <= '0;
                            r_oz     <= '0;
                            r_oid    <= '0;
                            r_odist  <= '0;
                            r_oempty <= 1'b1;
                            r_olast  <= 1'b1;
                            r_count  <= '0;
                            r_state  <= ST_RUN;
                        end else begin
                            // drop the query point itself, send entry one, advance the list
                            r_ox     <= r_x[1];
                            r_oy     <= r_y[1];
                            r_oz     <= r_z[1];
                            r_oid    <= r_id[1];
                            r_odist  <= r_dist[1];
                            r_oempty <= 1'b0;
                            r_olast  <= r_count == CW'(2);
                            for (int i = 0; i < NE - 1; i++) begin
                                r_dist[i] <= r_dist[i+1];
                                r_x[i]    <= r_x[i+1];
                                r_y[i]    <= r_y[i+1];
                                r_z[i]    <= r_z[i+1];
                                r_id[i]   <= r_id[i+1];
                            end
                            if (r_count == CW'(2)) begin
                                r_count <= '0;
                                r_state <= ST_RUN;
                            end else begin
                                r_count <= r_count - 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= ST_RUN;
            endcase
        end
    end

    assign o_valid        = r_ov;
    assign o_out_x        = r_ox;
    assign o_out_y        = r_oy;
    assign o_out_z        = r_oz;
    assign o_out_id       = r_oid;
    assign o_out_distance = r_odist;
    assign o_is_empty     = r_oempty;
    assign o_last_result  = r_olast;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(NE))
        else $error("held count beyond list size");

    a_last_ends_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && out_free && r_count <= CW'(2)) |=>
            (r_state == ST_RUN && r_count == '0 && r_ov && r_olast))
        else $error("query did not close on its final beat");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_oempty) |-> r_olast)
        else $error("empty beat not marked last");

endmodule

>>> rtl/core/knn_select_3d.sv
// A candidate marked last passes the two distance stages, the queue, the insert into the list
// and the output register; the results then follow at one per cycle while i_stall is low.
// Throughput: one item per cycle through the distance pipe and insertion list while o_stall is
// low; a query end holds the queue until its results (or one empty result) are sent, longer under stall.
// Reset (synchronous, active low): centre zero, list empty, k = 8, queue empty.
module knn_select_3d
    import knn_pkg::*;
#(
    parameter int MAX_NEIGHBOURS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_command,
    input  logic signed [COORD_W-1:0] i_x_coord,
    input  logic signed [COORD_W-1:0] i_y_coord,
    input  logic signed [COORD_W-1:0] i_z_coord,
    input  logic [ID_W-1:0]           i_point_id,
    input  logic                      i_last_candidate,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [COORD_W-1:0] o_out_x,
    output logic signed [COORD_W-1:0] o_out_y,
    output logic signed [COORD_W-1:0] o_out_z,
    output logic [ID_W-1:0]           o_out_id,
    output logic [DIST_W-1:0]         o_out_distance,
    output logic                      o_is_empty,
    output logic                      o_last_result
);

    logic              push, pop;
    t_item             push_item;
    t_q_head           head;
    logic [QLVL_W-1:0] q_level;

    knn_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_command        (i_command),
        .i_x_coord        (i_x_coord),
        .i_y_coord        (i_y_coord),
        .i_z_coord        (i_z_coord),
        .i_point_id       (i_point_id),
        .i_last_candidate (i_last_candidate),
        .i_q_level        (q_level),
        .o_push           (push),
        .o_push_item      (push_item)
    );

    knn_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .i_pop       (pop),
        .o_head      (head),
        .o_level     (q_level)
    );

    knn_back #(
        .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_head         (head),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_z        (o_out_z),
        .o_out_id       (o_out_id),
        .o_out_distance (o_out_distance),
        .o_is_empty     (o_is_empty),
        .o_last_result  (o_last_result)
    );

endmodule

>>> tb/tb_knn_select_3d.sv
module tb_knn_select_3d;
    import knn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_NBR   = 16;
    localparam int SETTLE_CY = 12;

    typedef struct packed {
        logic                      cmd;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [ID_W-1:0]           id;
        logic                      last;
    } point_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [ID_W-1:0]           id;
        logic [DIST_W-1:0]         dist_sq;
        logic                      empty;
        logic                      last;
    } neighbour_t;

    logic                      i_clk            = 1'b0;
    logic                      i_rst_n          = 1'b0;
    logic                      i_cfg_we         = 1'b0;
    logic [CFG_W-1:0]          i_cfg_data       = '0;
    logic                      i_valid          = 1'b0;
    logic                      o_stall;
    logic                      i_command        = CMD_CENTRE;
    logic signed [COORD_W-1:0] i_x_coord        = '0;
    logic signed [COORD_W-1:0] i_y_coord        = '0;
    logic signed [COORD_W-1:0] i_z_coord        = '0;
    logic [ID_W-1:0]           i_point_id       = '0;
    logic                      i_last_candidate = 1'b0;
    logic                      o_valid;
    logic                      i_stall          = 1'b0;
    logic signed [COORD_W-1:0] o_out_x;
    logic signed [COORD_W-1:0] o_out_y;
    logic signed [COORD_W-1:0] o_out_z;
    logic [ID_W-1:0]           o_out_id;
    logic [DIST_W-1:0]         o_out_distance;
    logic                      o_is_empty;
    logic                      o_last_result;

    knn_select_3d #(.MAX_NEIGHBOURS(MAX_NBR)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_x_coord       (i_x_coord),
        .i_y_coord       (i_y_coord),
        .i_z_coord       (i_z_coord),
        .i_point_id      (i_point_id),
        .i_last_candidate(i_last_candidate),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_out_z         (o_out_z),
        .o_out_id        (o_out_id),
        .o_out_distance  (o_out_distance),
        .o_is_empty      (o_is_empty),
        .o_last_result   (o_last_result)
    );

    always #5 i_clk = ~i_clk;

    // traffic and scoreboard
    point_item_t pending_points[$];
    neighbour_t  expected_nbrs[$];
    point_item_t cur_point;
    int          send_idle_pct  = 13;
    int          stall_pct      = 67;
    int          points_queued  = 0;
    int          points_sent    = 0;
    int          queries_closed = 0;
    int          beats_checked  = 0;
    int          mismatch_count = 0;

    // shadow of the block: centre, ranked list, k register
    logic signed [COORD_W-1:0] centre_x = '0;
    logic signed [COORD_W-1:0] centre_y = '0;
    logic signed [COORD_W-1:0] centre_z = '0;
    neighbour_t                ranked[MAX_NBR+1];
    int                        held_n   = 0;
    logic [CFG_W-1:0]          k_reg    = NBR_RESET;

    function automatic int active_k();
        int k;
        k = int'(k_reg);
        if (k < 1) k = 1;
        if (k > MAX_NBR) k = MAX_NBR;
        return k;
    endfunction

    function automatic logic [DIST_W-1:0] sq_distance(input logic signed [COORD_W-1:0] x,
                                                      input logic signed [COORD_W-1:0] y,
                                                      input logic signed [COORD_W-1:0] z);
        longint dx, dy, dz;
        dx = longint'(x) - longint'(centre_x);
        dy = longint'(y) - longint'(centre_y);
        dz = longint'(z) - longint'(centre_z);
        return DIST_W'(dx * dx + dy * dy + dz * dz);
    endfunction

    task automatic rank_point(input point_item_t p);
        int               cap, pos, i, n;
        logic [DIST_W-1:0] d;
        neighbour_t       r;
        if (p.cmd == CMD_CENTRE) begin
            centre_x = p.x;
            centre_y = p.y;
            centre_z = p.z;
            held_n   = 0;
            return;
        end
        cap = active_k() + 1;
        d   = sq_distance(p.x, p.y, p.z);
        // a lowered k trims the list first
        if (held_n > cap) held_n = cap;
        if (!(held_n == cap && d >= ranked[cap-1].dist_sq)) begin
            pos = 0;
            while (pos < held_n && ranked[pos].dist_sq <= d) pos++;
            i = (held_n < cap) ? held_n : cap - 1;
            while (i > pos) begin
                ranked[i] = ranked[i-1];
                i--;
            end
            ranked[pos] = '{x: p.x, y: p.y, z: p.z, id: p.id, dist_sq: d, empty: 1'b0,
                            last: 1'b0};
            if (held_n < cap) held_n++;
        end
        if (!p.last) return;
        queries_closed++;
        if (held_n <= 1) begin
            r       = '0;
            r.empty = 1'b1;
            r.last  = 1'b1;
            expected_nbrs.insert(expected_nbrs.size(), r);
        end else begin
            // drop the closest entry, it is the query point itself
            n = held_n - 1;
            if (n > active_k()) n = active_k();
            for (i = 0; i < n; i++) begin
                r      = ranked[i+1];
                r.last = (i == n - 1);
                expected_nbrs.insert(expected_nbrs.size(), r);
            end
        end
        held_n = 0;
    endtask

    // driver: present a beat, hold it while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                rank_point(cur_point);
                points_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_point = pending_points.pop_front();
                    i_valid          <= 1'b1;
                    i_command        <= cur_point.cmd;
                    i_x_coord        <= cur_point.x;
                    i_y_coord        <= cur_point.y;
                    i_z_coord        <= cur_point.z;
                    i_point_id       <= cur_point.id;
                    i_last_candidate <= cur_point.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // monitor: compare each neighbour beat against the oldest expectation
    always @(posedge i_clk) begin
        neighbour_t want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                beats_checked++;
                if (expected_nbrs.size() == 0) begin
                    report_mismatch("beat with nothing expected, id", o_out_id, 0);
                end else begin
                    want = expected_nbrs.pop_front();
                    check_field("out_x", o_out_x, want.x);
                    check_field("out_y", o_out_y, want.y);
                    check_field("out_z", o_out_z, want.z);
                    check_field("out_id", o_out_id, want.id);
                    check_field("out_distance", o_out_distance, want.dist_sq);
                    check_field("is_empty", o_is_empty, want.empty);
                    check_field("last_result", o_last_result, want.last);
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic push_point(input logic cmd, input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y,
                              input logic signed [COORD_W-1:0] z,
                              input logic [ID_W-1:0] id, input logic last);
        pending_points.insert(pending_points.size(),
                              '{cmd: cmd, x: x, y: y, z: z, id: id, last: last});
        points_queued++;
    endtask

    // hold until the block is empty, then let the pipe run dry
    task automatic settle();
        wait (pending_points.size() == 0 && !i_valid && expected_nbrs.size() == 0);
        repeat (SETTLE_CY) @(posedge i_clk);
    endtask

    task automatic write_k(input logic [CFG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        k_reg = v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord(
            input logic signed [COORD_W-1:0] near);
        case ($urandom_range(3))
            0, 1:    return COORD_W'(near + $urandom_range(16) - 8);
            2:       return COORD_W'($urandom);
            default: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    task automatic add_query();
        logic signed [COORD_W-1:0] cx, cy, cz;
        int                        ncand, self_at, j;
        // noise: stray candidates, bare centres, loose last marks
        if ($urandom_range(99) < 12) begin
            ncand = $urandom_range(1, 3);
            for (j = 0; j < ncand; j++)
                push_point(($urandom_range(3) == 0) ? CMD_CENTRE : CMD_POINT,
                           COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                           ID_W'($urandom), 1'($urandom_range(1)));
            return;
        end
        cx = pick_coord(COORD_W'($urandom));
        cy = pick_coord(COORD_W'($urandom));
        cz = pick_coord(COORD_W'($urandom));
        push_point(CMD_CENTRE, cx, cy, cz, ID_W'($urandom), 1'($urandom_range(1)));
        ncand   = ($urandom_range(3) == 0) ? $urandom_range(12, 22) : $urandom_range(1, 7);
        self_at = ($urandom_range(9) < 7) ? $urandom_range(ncand - 1) : ncand;
        for (j = 0; j < ncand; j++) begin
            if (j == self_at)
                push_point(CMD_POINT, cx, cy, cz, ID_W'($urandom), j == ncand - 1);
            else
                push_point(CMD_POINT, pick_coord(cx), pick_coord(cy), pick_coord(cz),
                           ID_W'($urandom), j == ncand - 1);
        end
    endtask

    task automatic random_phase(input logic [CFG_W-1:0] k, input int idle, input int stall,
                                input int count);
        int stop_at;
        settle();
        write_k(k);
        send_idle_pct = idle;
        stall_pct     = stall;
        stop_at       = points_queued + count;
        while (points_queued < stop_at) add_query();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset k: a lone candidate, extremes, ties, too few candidates
        push_point(CMD_POINT, 16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF, 1'b1);
        push_point(CMD_CENTRE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 1'b1);
        push_point(CMD_POINT, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h0001, 1'b0);
        push_point(CMD_POINT, 16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF, 1'b0);
        push_point(CMD_POINT, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000, 1'b0);
        push_point(CMD_POINT, 16'sh7FFE, 16'sh7FFF, 16'sh7FFF, 16'h0002, 1'b0);
        push_point(CMD_POINT, 16'sh7FFF, 16'sh7FFE, 16'sh7FFF, 16'h0003, 1'b0);
        push_point(CMD_POINT, 16'sh7FFF, 16'sh7FFF, 16'sh7FFE, 16'h0004, 1'b1);
        push_point(CMD_CENTRE, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000, 1'b0);
        push_point(CMD_POINT, 16'sh0005, -16'sh0005, 16'sh0005, 16'h8000, 1'b1);
        // centre is kept after a query closes
        push_point(CMD_POINT, 16'sh0001, 16'sh0000, 16'sh0000, 16'h0007, 1'b0);
        push_point(CMD_POINT, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0008, 1'b1);

        // k of zero acts as one; a full list drops a candidate that ties its tail
        settle();
        write_k(5'd0);
        push_point(CMD_CENTRE, 16'sh8000, 16'sh8000, 16'sh8000, 16'h1234, 1'b0);
        push_point(CMD_POINT, 16'sh8000, 16'sh8000, 16'sh8000, 16'h0010, 1'b0);
        push_point(CMD_POINT, 16'sh8010, 16'sh8000, 16'sh8000, 16'h0011, 1'b0);
        push_point(CMD_POINT, 16'sh8000, 16'sh8010, 16'sh8000, 16'h0012, 1'b0);
        push_point(CMD_POINT, 16'sh8003, 16'sh8000, 16'sh8000, 16'h0013, 1'b1);

        // open a query at k above the maximum, then lower k before it closes
        settle();
        write_k(5'd31);
        push_point(CMD_CENTRE, 16'sh0064, -16'sh0064, 16'sh0000, 16'h0000, 1'b0);
        push_point(CMD_POINT, 16'sh0064, -16'sh0064, 16'sh0000, 16'h0020, 1'b0);
        push_point(CMD_POINT, 16'sh0070, -16'sh0064, 16'sh0000, 16'h0021, 1'b0);
        push_point(CMD_POINT, 16'sh0064, -16'sh0050, 16'sh0000, 16'h0022, 1'b0);
        push_point(CMD_POINT, 16'sh0066, -16'sh0064, 16'sh0000, 16'h0023, 1'b0);
        push_point(CMD_POINT, 16'sh0064, -16'sh0064, 16'sh0009, 16'h0024, 1'b0);
        settle();
        write_k(5'd2);
        push_point(CMD_POINT, 16'sh0064, -16'sh0065, 16'sh0000, 16'h0025, 1'b1);

        random_phase(5'd16, 13, 67, 30);
        random_phase(5'd5, 67, 13, 30);
        random_phase(5'd31, 0, 0, 30);
        random_phase(5'd1, 0, 0, 25);
        settle();

        $display("tb_knn_select_3d: %0d points sent, %0d queries closed, %0d neighbour beats",
                 points_sent, queries_closed, beats_checked);
        $display("tb_knn_select_3d: k written as 0, 31, 2, 16, 5, 1 under mixed stall patterns");
        if (mismatch_count == 0) begin
            $display("tb_knn_select_3d: done, clean");
        end else begin
            $display("tb_knn_select_3d: done, errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_knn_select_3d: done, errors");
        $finish;
    end

endmodule
